### hw/rtl/mtm_pkg.sv
// ----------------------------------------------------------------------------
// Shift-key multitouch mapper package
// Shared types, event codes and configuration register indexes.
// ----------------------------------------------------------------------------
package mtm_pkg;

  // Emitted event types.
  localparam logic [15:0] EVT_SYN = 16'd0;
  localparam logic [15:0] EVT_KEY = 16'd1;
  localparam logic [15:0] EVT_ABS = 16'd3;

  // Emitted event codes.
  localparam logic [15:0] SYNC_REPORT    = 16'd0;
  localparam logic [15:0] SYNC_MT_REPORT = 16'd2;
  localparam logic [15:0] AXIS_SLOT      = 16'h002f;
  localparam logic [15:0] AXIS_X         = 16'h0035;
  localparam logic [15:0] AXIS_Y         = 16'h0036;
  localparam logic [15:0] AXIS_TRACK     = 16'h0039;

  // Key codes of interest.
  localparam logic [15:0] CODE_LSHIFT = 16'd42;
  localparam logic [15:0] CODE_RSHIFT = 16'd54;

  // Configuration register indexes.
  localparam logic [2:0] REG_PROTOCOL_B  = 3'd0;
  localparam logic [2:0] REG_ROTATION    = 3'd1;
  localparam logic [2:0] REG_SCREEN_H    = 3'd2;
  localparam logic [2:0] REG_SCREEN_W    = 3'd3;
  localparam logic [2:0] REG_MARGIN_H    = 3'd4;
  localparam logic [2:0] REG_MARGIN_V    = 3'd5;
  localparam logic [2:0] REG_STATUS_BAR  = 3'd6;

  // Rotation codes.
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // Button state snapshot handed from the front to the back.
  typedef struct packed {
    logic left;
    logic right;
  } cmd_t;

  // Configuration as seen by the sequencer.
  typedef struct packed {
    logic        protocol_b;
    logic [1:0]  rotation;
    logic [11:0] disp_height;
    logic [11:0] disp_width;
    logic [11:0] margin_horizontal;
    logic [11:0] margin_vertical;
    logic [11:0] bar_height;
  } cfg_t;

  // Queue status.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### hw/rtl/mtm_front.sv
// ----------------------------------------------------------------------------
// Shift-key multitouch mapper front end
// Accepts input events, filters shift key events and tracks the pressed flags.
// ----------------------------------------------------------------------------
module mtm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          in_event_type,
  input  logic [15:0]          in_event_code,
  input  logic [31:0]          in_event_value,
  input  mtm_pkg::q_stat_t     q_stat,
  output logic                 q_push,
  output mtm_pkg::cmd_t        q_cmd
);
  import mtm_pkg::*;

  logic left_r, left_nxt;
  logic right_r, right_nxt;
  logic accept;
  logic le_one;
  logic pressed;
  logic is_left;
  logic is_right;
  logic is_key;

  // Hold off new items while the queue has no room.
  assign in_stall = q_stat.full;
  assign accept   = in_valid & ~in_stall;

  // Classify the item: key events with a value of at most one, on a shift key.
  assign le_one   = in_event_value[31] | (in_event_value == 32'd0) |
                    (in_event_value == 32'd1);
  assign pressed  = (in_event_value != 32'd0);
  assign is_key   = (in_event_type == EVT_KEY) & le_one;
  assign is_left  = is_key & (in_event_code == CODE_LSHIFT);
  assign is_right = is_key & (in_event_code == CODE_RSHIFT);

  // Next flag values.
  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    if (accept && is_left) begin
      left_nxt = pressed;
    end
    if (accept && is_right) begin
      right_nxt = pressed;
    end
  end

  // A shift event queues a report of the updated flags.
  assign q_push      = accept & (is_left | is_right);
  assign q_cmd.left  = left_nxt;
  assign q_cmd.right = right_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= 1'b0;
      right_r <= 1'b0;
    end else begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

endmodule

### hw/rtl/mtm_queue.sv
// ----------------------------------------------------------------------------
// Shift-key multitouch mapper report queue
// Two-entry queue of button snapshots between the front end and the sequencer.
// ----------------------------------------------------------------------------
module mtm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mtm_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output mtm_pkg::cmd_t    head,
  output mtm_pkg::q_stat_t stat
);
  import mtm_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign head       = mem_r[rd_ptr_r];

  assign do_push = push & ~stat.full;
  assign do_pop  = pop & ~stat.empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### hw/rtl/mtm_back.sv
// ----------------------------------------------------------------------------
// Shift-key multitouch mapper sequencer
// Expands a snapshot into its multitouch report, one event a cycle unless stalled.
// ----------------------------------------------------------------------------
module mtm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mtm_pkg::cfg_t     cfg,
  input  mtm_pkg::q_stat_t  q_stat,
  input  mtm_pkg::cmd_t     q_head,
  output logic              q_pop,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_type,
  output logic [15:0]       out_code,
  output logic signed [12:0] out_value,
  output logic              out_last
);
  import mtm_pkg::*;

  // Sequencer step codes.
  localparam logic [2:0] ST_SLOT = 3'd0;
  localparam logic [2:0] ST_TRK  = 3'd1;
  localparam logic [2:0] ST_X    = 3'd2;
  localparam logic [2:0] ST_Y    = 3'd3;
  localparam logic [2:0] ST_MT   = 3'd4;
  localparam logic [2:0] ST_SYN  = 3'd5;

  localparam logic [12:0] VAL_RELEASE = 13'h1fff;

  logic        busy_r, busy_nxt;
  logic [2:0]  st_r, st_nxt;
  logic        side_r, side_nxt;
  logic        left_r, left_nxt;
  logic        right_r, right_nxt;
  logic        out_valid_r;
  logic [15:0] out_type_r;
  logic [15:0] out_code_r;
  logic [12:0] out_value_r;
  logic        out_last_r;

  logic        out_free;
  logic        emit;
  logic        done_now;
  logic        load;
  logic        side_pressed;
  logic [15:0] ev_type;
  logic [15:0] ev_code;
  logic [12:0] ev_value;
  logic [11:0] lx, ly, rx, ry;
  logic [11:0] h_minus_mv, w_minus_mh, sb_plus_mv;
  logic [12:0] sb_sum;

  // Clamped difference and saturated sum of coordinates.
  assign h_minus_mv = (cfg.disp_height > cfg.margin_vertical) ?
                      (cfg.disp_height - cfg.margin_vertical) : 12'd0;
  assign w_minus_mh = (cfg.disp_width > cfg.margin_horizontal) ?
                      (cfg.disp_width - cfg.margin_horizontal) : 12'd0;
  assign sb_sum     = {1'b0, cfg.bar_height} + {1'b0, cfg.margin_vertical};
  assign sb_plus_mv = sb_sum[12] ? 12'hfff : sb_sum[11:0];

  // Button positions for the current rotation.
  always_comb begin
    unique case (cfg.rotation)
      ROT_270: begin
        lx = h_minus_mv; ly = w_minus_mh;
        rx = h_minus_mv; ry = cfg.margin_horizontal;
      end
      ROT_180: begin
        lx = w_minus_mh;            ly = sb_plus_mv;
        rx = cfg.margin_horizontal; ry = sb_plus_mv;
      end
      ROT_90: begin
        lx = sb_plus_mv; ly = cfg.margin_horizontal;
        rx = sb_plus_mv; ry = w_minus_mh;
      end
      default: begin
        lx = cfg.margin_horizontal; ly = h_minus_mv;
        rx = w_minus_mh;            ry = h_minus_mv;
      end
    endcase
  end

  assign side_pressed = side_r ? right_r : left_r;

  // Event for the current step.
  always_comb begin
    ev_type  = EVT_ABS;
    ev_code  = AXIS_SLOT;
    ev_value = 13'd0;
    unique case (st_r)
      ST_SLOT: begin
        ev_code  = AXIS_SLOT;
        ev_value = side_r ? 13'd2 : 13'd1;
      end
      ST_TRK: begin
        ev_code  = AXIS_TRACK;
        if (side_pressed) begin
          ev_value = side_r ? 13'd2 : 13'd1;
        end else begin
          ev_value = VAL_RELEASE;
        end
      end
      ST_X: begin
        ev_code  = AXIS_X;
        ev_value = {1'b0, (side_r ? rx : lx)};
      end
      ST_Y: begin
        ev_code  = AXIS_Y;
        ev_value = {1'b0, (side_r ? ry : ly)};
      end
      ST_MT: begin
        ev_type = EVT_SYN;
        ev_code = SYNC_MT_REPORT;
      end
      default: begin
        ev_type = EVT_SYN;
        ev_code = SYNC_REPORT;
      end
    endcase
  end

  // The report ends on the sync after the right slot, or the only sync in protocol A.
  assign done_now = (st_r == ST_SYN) & (~cfg.protocol_b | side_r);

  assign out_free = ~out_valid_r | ~out_stall;
  assign emit     = busy_r & out_free;
  assign load     = ~q_stat.empty & (~busy_r | (emit & done_now));
  assign q_pop    = load;
  assign busy     = busy_r;

  // Step sequencing.
  always_comb begin
    busy_nxt  = busy_r;
    st_nxt    = st_r;
    side_nxt  = side_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    if (emit) begin
      unique case (st_r)
        ST_SLOT: st_nxt = ST_TRK;
        ST_TRK:  st_nxt = (cfg.protocol_b && !side_pressed) ? ST_SYN : ST_X;
        ST_X:    st_nxt = ST_Y;
        ST_Y:    st_nxt = cfg.protocol_b ? ST_SYN : ST_MT;
        ST_MT: begin
          if (!side_r && right_r) begin
            st_nxt   = ST_TRK;
            side_nxt = 1'b1;
          end else begin
            st_nxt = ST_SYN;
          end
        end
        default: begin
          if (done_now) begin
            busy_nxt = 1'b0;
          end else begin
            st_nxt   = ST_SLOT;
            side_nxt = 1'b1;
          end
        end
      endcase
    end
    // A new snapshot starts at its first step.
    if (load) begin
      busy_nxt  = 1'b1;
      left_nxt  = q_head.left;
      right_nxt = q_head.right;
      if (cfg.protocol_b) begin
        st_nxt   = ST_SLOT;
        side_nxt = 1'b0;
      end else if (q_head.left) begin
        st_nxt   = ST_TRK;
        side_nxt = 1'b0;
      end else if (q_head.right) begin
        st_nxt   = ST_TRK;
        side_nxt = 1'b1;
      end else begin
        st_nxt   = ST_MT;
        side_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      st_r        <= ST_SLOT;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      st_r   <= st_nxt;
      side_r <= side_nxt;
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  // Snapshot and output payload registers.
  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
    if (emit) begin
      out_type_r  <= ev_type;
      out_code_r  <= ev_code;
      out_value_r <= ev_value;
      out_last_r  <= done_now;
    end
  end

  assign out_valid = out_valid_r;
  assign out_type  = out_type_r;
  assign out_code  = out_code_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

### hw/rtl/key_to_multitouch_event_mapper_unit.sv
// A shift event's snapshot passes through the report queue and the sequencer state
// before its first report event is registered at the output. Throughput: one report
// event per cycle from the sequencer while the output is not stalled; a report is
// 2 to 10 events, and other items cause none. Input items are taken every cycle while
// the two-entry report queue has room. Reset (synchronous, active low) releases both
// buttons, empties the queue and loads the configuration defaults.
// ----------------------------------------------------------------------------
// Shift-key multitouch mapper
// Maps left and right shift key events onto multitouch protocol A or B reports.
// ----------------------------------------------------------------------------
module key_to_multitouch_event_mapper_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_event_type,
  input  logic [15:0]        in_event_code,
  input  logic signed [31:0] in_event_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_type,
  output logic [15:0]        out_code,
  output logic signed [12:0] out_value,
  output logic               out_last
);
  import mtm_pkg::*;

  cfg_t    cfg_r;
  q_stat_t q_stat;
  cmd_t    q_cmd;
  cmd_t    q_head;
  logic    q_push;
  logic    q_pop;
  logic    bk_busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.protocol_b        <= 1'b0;
      cfg_r.rotation          <= ROT_270;
      cfg_r.disp_height       <= 12'd976;
      cfg_r.disp_width        <= 12'd600;
      cfg_r.margin_horizontal <= 12'd80;
      cfg_r.margin_vertical   <= 12'd50;
      cfg_r.bar_height        <= 12'd48;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROTOCOL_B: cfg_r.protocol_b        <= cfg_data[0];
        REG_ROTATION:   cfg_r.rotation          <= cfg_data[1:0];
        REG_SCREEN_H:   cfg_r.disp_height       <= cfg_data;
        REG_SCREEN_W:   cfg_r.disp_width        <= cfg_data;
        REG_MARGIN_H:   cfg_r.margin_horizontal <= cfg_data;
        REG_MARGIN_V:   cfg_r.margin_vertical   <= cfg_data;
        REG_STATUS_BAR: cfg_r.bar_height        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: filtering and button flags.
  mtm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_event_type  (in_event_type),
    .in_event_code  (in_event_code),
    .in_event_value (in_event_value),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  // Snapshot queue.
  mtm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // Report sequencer and output register.
  mtm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .busy      (bk_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_type  (out_type),
    .out_code  (out_code),
    .out_value (out_value),
    .out_last  (out_last)
  );

  // The front never pushes into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
    else $error("report pushed into a full queue");

  // A queued snapshot is either still queued or being sequenced.
  assert property (@(posedge clk) disable iff (!rst_n) q_push |=> !q_stat.empty || bk_busy)
    else $error("queued report was lost");

  // The final event of a report is always a sync report.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_type == EVT_SYN && out_code == SYNC_REPORT)
    else $error("report ended on an event other than a sync report");

  // The sequencer pops only when it has something to pop.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// Shift-key multitouch mapper testbench
// Sends key events through the input channel and predicts every multitouch
// report event in protocol A and protocol B, for all rotations and for
// geometry settings that clamp and saturate. Random sender bursts and
// receiver stalls exercise the handshakes. Each emitted event is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import mtm_pkg::*;

  // One emitted report event as the output channel carries it.
  typedef struct packed {
    logic [15:0]        ev_type;
    logic [15:0]        code;
    logic signed [12:0] value;
    logic               last;
  } mt_event_t;

  // One directed key item with the number of report events it must cause.
  typedef struct packed {
    logic [15:0]        ev_type;
    logic [15:0]        code;
    logic signed [31:0] value;
    logic [3:0]         n_events;
  } key_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [11:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [15:0]        in_event_type = '0;
  logic [15:0]        in_event_code = '0;
  logic signed [31:0] in_event_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        out_type;
  logic [15:0]        out_code;
  logic signed [12:0] out_value;
  logic               out_last;

  // Shadow of the block's configuration and button flags.
  cfg_t      cfg_shadow;
  logic      left_down;
  logic      right_down;
  mt_event_t pending_events [$];
  int        mismatch_count = 0;
  int        burst_left = 0;
  logic      hold_req = 1'b0;

  // Directed items at the reset configuration: protocol A, rotation 270.
  key_row_t key_rows [19] = '{
    '{EVT_KEY, CODE_LSHIFT, 32'sd1, 4'd5},
    '{EVT_KEY, CODE_LSHIFT, 32'sd2, 4'd0},
    '{EVT_KEY, CODE_RSHIFT, 32'sd1, 4'd9},
    '{EVT_KEY, CODE_RSHIFT, 32'h7fffffff, 4'd0},
    '{EVT_KEY, CODE_LSHIFT, 32'sd0, 4'd5},
    '{EVT_KEY, CODE_RSHIFT, 32'sd0, 4'd2},
    '{EVT_KEY, CODE_LSHIFT, -32'sd1, 4'd5},
    '{EVT_KEY, CODE_RSHIFT, 32'h80000000, 4'd9},
    '{EVT_SYN, CODE_LSHIFT, 32'sd1, 4'd0},
    '{16'hffff, CODE_RSHIFT, 32'sd0, 4'd0},
    '{EVT_KEY, 16'hffff, 32'sd1, 4'd0},
    '{EVT_KEY, 16'h0000, 32'sd0, 4'd0},
    '{EVT_KEY, 16'd43, 32'sd1, 4'd0},
    '{EVT_KEY, 16'h8036, 32'sd0, 4'd0},
    '{16'h8001, CODE_LSHIFT, 32'sd0, 4'd0},
    '{EVT_KEY, CODE_LSHIFT, 32'sd0, 4'd5},
    '{EVT_KEY, CODE_RSHIFT, 32'sd0, 4'd2},
    '{EVT_KEY, CODE_RSHIFT, 32'sd0, 4'd2},
    '{EVT_KEY, CODE_LSHIFT, 32'sd1, 4'd5}
  };

  // Configuration phases, with the clamping and saturating extremes.
  cfg_t cfg_phases [7] = '{
    '{1'b1, ROT_0,   12'd976,  12'd600,  12'd80,   12'd50,   12'd48},
    '{1'b0, ROT_90,  12'd600,  12'd976,  12'd80,   12'd50,   12'd48},
    '{1'b1, ROT_180, 12'd976,  12'd600,  12'd80,   12'd50,   12'd48},
    '{1'b0, ROT_0,   12'd0,    12'd0,    12'd4095, 12'd4095, 12'd4095},
    '{1'b1, ROT_90,  12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095},
    '{1'b0, ROT_180, 12'd4095, 12'd4095, 12'd0,    12'd0,    12'd0},
    '{1'b1, ROT_270, 12'd0,    12'd4095, 12'd4095, 12'd0,    12'd4095}
  };

  key_to_multitouch_event_mapper_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_event_type  (in_event_type),
    .in_event_code  (in_event_code),
    .in_event_value (in_event_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_type       (out_type),
    .out_code       (out_code),
    .out_value      (out_value),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Coordinate difference that stops at zero.
  function automatic logic [11:0] diff_floor(input logic [11:0] a, input logic [11:0] b);
    return (a > b) ? a - b : 12'd0;
  endfunction

  // Coordinate sum that stops at the largest coordinate.
  function automatic logic [11:0] sum_sat(input logic [11:0] a, input logic [11:0] b);
    logic [12:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[12] ? 12'hfff : s[11:0];
  endfunction

  function automatic mt_event_t mk_event(input logic [15:0] t, input logic [15:0] c,
                                         input logic signed [12:0] v);
    mt_event_t e;
    e.ev_type = t;
    e.code    = c;
    e.value   = v;
    e.last    = 1'b0;
    return e;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Update the button flags for one accepted item and queue the report it causes.
  task automatic predict_report(input logic [15:0] t, input logic [15:0] c,
                                input logic signed [31:0] v, output int n);
    mt_event_t   rep [$];
    logic [11:0] lx, ly, rx, ry;
    logic [11:0] h, w, mh, mv, sb;
    n = 0;
    if (t != EVT_KEY || v > 1) return;
    if (c == CODE_LSHIFT) left_down = (v != 0);
    else if (c == CODE_RSHIFT) right_down = (v != 0);
    else return;

    h  = cfg_shadow.disp_height;
    w  = cfg_shadow.disp_width;
    mh = cfg_shadow.margin_horizontal;
    mv = cfg_shadow.margin_vertical;
    sb = cfg_shadow.bar_height;
    case (cfg_shadow.rotation)
      ROT_0: begin
        lx = mh;                ly = diff_floor(h, mv);
        rx = diff_floor(w, mh); ry = diff_floor(h, mv);
      end
      ROT_90: begin
        lx = sum_sat(sb, mv);   ly = mh;
        rx = sum_sat(sb, mv);   ry = diff_floor(w, mh);
      end
      ROT_180: begin
        lx = diff_floor(w, mh); ly = sum_sat(sb, mv);
        rx = mh;                ry = sum_sat(sb, mv);
      end
      default: begin
        lx = diff_floor(h, mv); ly = diff_floor(w, mh);
        rx = diff_floor(h, mv); ry = mh;
      end
    endcase

    if (!cfg_shadow.protocol_b) begin
      // Protocol A: one block per pressed button, or a lone MT report.
      if (!left_down && !right_down) rep.push_back(mk_event(EVT_SYN, SYNC_MT_REPORT, 13'sd0));
      if (left_down) begin
        rep.push_back(mk_event(EVT_ABS, AXIS_TRACK, 13'sd1));
        rep.push_back(mk_event(EVT_ABS, AXIS_X, $signed({1'b0, lx})));
        rep.push_back(mk_event(EVT_ABS, AXIS_Y, $signed({1'b0, ly})));
        rep.push_back(mk_event(EVT_SYN, SYNC_MT_REPORT, 13'sd0));
      end
      if (right_down) begin
        rep.push_back(mk_event(EVT_ABS, AXIS_TRACK, 13'sd2));
        rep.push_back(mk_event(EVT_ABS, AXIS_X, $signed({1'b0, rx})));
        rep.push_back(mk_event(EVT_ABS, AXIS_Y, $signed({1'b0, ry})));
        rep.push_back(mk_event(EVT_SYN, SYNC_MT_REPORT, 13'sd0));
      end
      rep.push_back(mk_event(EVT_SYN, SYNC_REPORT, 13'sd0));
    end else begin
      // Protocol B: both slots always, a released slot gets tracking id -1.
      rep.push_back(mk_event(EVT_ABS, AXIS_SLOT, 13'sd1));
      if (left_down) begin
        rep.push_back(mk_event(EVT_ABS, AXIS_TRACK, 13'sd1));
        rep.push_back(mk_event(EVT_ABS, AXIS_X, $signed({1'b0, lx})));
        rep.push_back(mk_event(EVT_ABS, AXIS_Y, $signed({1'b0, ly})));
      end else begin
        rep.push_back(mk_event(EVT_ABS, AXIS_TRACK, -13'sd1));
      end
      rep.push_back(mk_event(EVT_SYN, SYNC_REPORT, 13'sd0));
      rep.push_back(mk_event(EVT_ABS, AXIS_SLOT, 13'sd2));
      if (right_down) begin
        rep.push_back(mk_event(EVT_ABS, AXIS_TRACK, 13'sd2));
        rep.push_back(mk_event(EVT_ABS, AXIS_X, $signed({1'b0, rx})));
        rep.push_back(mk_event(EVT_ABS, AXIS_Y, $signed({1'b0, ry})));
      end else begin
        rep.push_back(mk_event(EVT_ABS, AXIS_TRACK, -13'sd1));
      end
      rep.push_back(mk_event(EVT_SYN, SYNC_REPORT, 13'sd0));
    end
    rep[rep.size() - 1].last = 1'b1;
    n = rep.size();
    foreach (rep[i]) pending_events.push_back(rep[i]);
  endtask

  // Present one item and hold it until the block takes it.
  task automatic offer(input logic [15:0] t, input logic [15:0] c,
                       input logic signed [31:0] v, output int n);
    in_valid       <= 1'b1;
    in_event_type  <= t;
    in_event_code  <= c;
    in_event_value <= v;
    do @(posedge clk); while (in_stall);
    predict_report(t, c, v, n);
  endtask

  // Sender pacing: keep valid high inside a burst, otherwise idle for a while.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  // Stop sending and wait until every predicted event has come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [11:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic apply_cfg(input cfg_t c);
    reg_write(REG_PROTOCOL_B, {11'd0, c.protocol_b});
    reg_write(REG_ROTATION, {10'd0, c.rotation});
    reg_write(REG_SCREEN_H, c.disp_height);
    reg_write(REG_SCREEN_W, c.disp_width);
    reg_write(REG_MARGIN_H, c.margin_horizontal);
    reg_write(REG_MARGIN_V, c.margin_vertical);
    reg_write(REG_STATUS_BAR, c.bar_height);
    cfg_we <= 1'b0;
    cfg_shadow = c;
  endtask

  // Mostly well-formed shift presses and releases, with some ignored and noise items.
  task automatic random_item(output logic [15:0] t, output logic [15:0] c,
                             output logic signed [31:0] v);
    int r;
    r = $urandom_range(0, 99);
    t = EVT_KEY;
    c = $urandom_range(0, 1) ? CODE_RSHIFT : CODE_LSHIFT;
    if (r < 70) begin
      v = $urandom_range(0, 1);
    end else if (r < 80) begin
      v = $urandom_range(0, 1) ? $urandom : 32'sd2;
    end else if (r < 90) begin
      c = 16'($urandom_range(0, 65535));
      v = $urandom_range(0, 1);
    end else begin
      t = 16'($urandom_range(0, 65535));
      c = 16'($urandom_range(0, 65535));
      v = $urandom;
    end
  endtask

  // Random items until the requested number of them have caused a report.
  task automatic run_random(input int n_reports);
    logic [15:0]        t, c;
    logic signed [31:0] v;
    int                 n;
    int                 got;
    got = 0;
    while (got < n_reports) begin
      random_item(t, c, v);
      pace();
      offer(t, c, v, n);
      if (n != 0) got++;
    end
  endtask

  // Receiver: stall modes of random length, and one long hold-off on request.
  initial begin : receiver
    int   mode;
    int   mode_left;
    logic hold_taken;
    mode       = 0;
    mode_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 4) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Compare each accepted event with the oldest prediction.
  always @(posedge clk) begin : check_output
    mt_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected event type %0d code %0d value %0d last %0b",
                                out_type, out_code, out_value, out_last));
      end else begin
        want = pending_events.pop_front();
        if (out_type !== want.ev_type)
          flag_mismatch($sformatf("type %0d, expected %0d", out_type, want.ev_type));
        if (out_code !== want.code)
          flag_mismatch($sformatf("code %0d, expected %0d", out_code, want.code));
        if (out_value !== want.value)
          flag_mismatch($sformatf("value %0d, expected %0d", out_value, want.value));
        if (out_last !== want.last)
          flag_mismatch($sformatf("last %0b, expected %0b", out_last, want.last));
      end
    end
  end

  // Main sequence: reset, directed items, then random items per configuration.
  initial begin : stimulus
    int   n;
    cfg_t rnd_cfg;
    cfg_shadow = '{1'b0, ROT_270, 12'd976, 12'd600, 12'd80, 12'd50, 12'd48};
    left_down  = 1'b0;
    right_down = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (key_rows[i]) begin
      pace();
      offer(key_rows[i].ev_type, key_rows[i].code, key_rows[i].value, n);
      if (n != key_rows[i].n_events)
        flag_mismatch($sformatf("directed item %0d gave %0d events, expected %0d",
                                i, n, key_rows[i].n_events));
    end
    run_random(12);
    settle();

    foreach (cfg_phases[p]) begin
      apply_cfg(cfg_phases[p]);
      // Long receiver hold-off while items keep coming back to back.
      if (p == 2) begin
        hold_req <= 1'b1;
        for (int k = 0; k < 14; k++)
          offer(EVT_KEY, (k % 2) ? CODE_RSHIFT : CODE_LSHIFT, $urandom_range(0, 1), n);
      end
      run_random(12);
      settle();
    end

    rnd_cfg.protocol_b        = 1'($urandom_range(0, 1));
    rnd_cfg.rotation          = 2'($urandom_range(0, 3));
    rnd_cfg.disp_height       = 12'($urandom_range(0, 4095));
    rnd_cfg.disp_width        = 12'($urandom_range(0, 4095));
    rnd_cfg.margin_horizontal = 12'($urandom_range(0, 4095));
    rnd_cfg.margin_vertical   = 12'($urandom_range(0, 4095));
    rnd_cfg.bar_height        = 12'($urandom_range(0, 4095));
    apply_cfg(rnd_cfg);
    run_random(12);
    settle();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake or missing events.
  initial begin : watchdog
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### key_to_multitouch_event_mapper_unit.f
hw/rtl/mtm_pkg.sv
hw/rtl/mtm_front.sv
hw/rtl/mtm_queue.sv
hw/rtl/mtm_back.sv
hw/rtl/key_to_multitouch_event_mapper_unit.sv
verif/tb.sv
